// ===== rtl/rptd_pkg.sv =====
package rptd_pkg;

  localparam int TIMER_BITS = 16;
  localparam int FS_BITS    = 15;
  localparam int PROD_BITS  = TIMER_BITS + FS_BITS;
  localparam int DIV_STEPS  = PROD_BITS;
  localparam int CNT_BITS   = $clog2(DIV_STEPS);
  localparam int CFG_BITS   = 16;
  localparam int IDX_BITS   = 3;

  typedef logic [IDX_BITS-1:0] reg_idx_t;
  localparam reg_idx_t REG_ENABLE       = 3'd0;
  localparam reg_idx_t REG_WIDTH_MIN    = 3'd1;
  localparam reg_idx_t REG_WIDTH_MID    = 3'd2;
  localparam reg_idx_t REG_WIDTH_MAX    = 3'd3;
  localparam reg_idx_t REG_DEAD_BAND    = 3'd4;
  localparam reg_idx_t REG_VALID_MARGIN = 3'd5;
  localparam reg_idx_t REG_FULL_SCALE   = 3'd6;
  localparam reg_idx_t REG_ZERO_OOR     = 3'd7;

  typedef struct packed {
    logic               enable;
    logic [15:0]        width_min;
    logic [15:0]        width_mid;
    logic [15:0]        width_max;
    logic [14:0]        dead_band;
    logic [14:0]        valid_margin;
    logic [FS_BITS-1:0] full_scale;
    logic               zero_oor;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    RG_OUT,
    RG_NEG,
    RG_LIN_NEG,
    RG_ZERO,
    RG_LIN_POS,
    RG_POS
  } region_t;

  typedef struct packed {
    logic capture;
    logic classify;
    logic mul;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fall;
    logic linear;
    logic emit;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/rptd_regs.sv =====
module rptd_regs
  import rptd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  reg_idx_t            cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable       <= 1'b0;
      cfg.width_min    <= 16'd1000;
      cfg.width_mid    <= 16'd1500;
      cfg.width_max    <= 16'd2000;
      cfg.dead_band    <= 15'd20;
      cfg.valid_margin <= 15'd200;
      cfg.full_scale   <= 15'd1000;
      cfg.zero_oor     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:       cfg.enable       <= cfg_data[0];
        REG_WIDTH_MIN:    cfg.width_min    <= cfg_data[15:0];
        REG_WIDTH_MID:    cfg.width_mid    <= cfg_data[15:0];
        REG_WIDTH_MAX:    cfg.width_max    <= cfg_data[15:0];
        REG_DEAD_BAND:    cfg.dead_band    <= cfg_data[14:0];
        REG_VALID_MARGIN: cfg.valid_margin <= cfg_data[14:0];
        REG_FULL_SCALE:   cfg.full_scale   <= cfg_data[FS_BITS-1:0];
        REG_ZERO_OOR:     cfg.zero_oor     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/rptd_ctrl.sv =====
module rptd_ctrl
  import rptd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && st.fall) state_next = ST_CLASSIFY;
      end
      ST_CLASSIFY: state_next = ST_MUL;
      ST_MUL: begin
        state_next = st.linear ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (st.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!st.emit || st.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_CLASSIFY: cmd.classify = 1'b1;
      ST_MUL:      cmd.mul      = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_DONE:     cmd.out_load = st.emit && st.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/rptd_dp.sv =====
module rptd_dp
  import rptd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  cmd_t                    cmd,
  output status_t                 st,
  input  logic [TIMER_BITS-1:0]   capture_time,
  input  logic                    pin_level,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2*TIMER_BITS-1:0] out_data
);

  localparam int CW = TIMER_BITS + 2;

  logic [TIMER_BITS-1:0] rise_time;
  logic                  high_seen;
  logic [TIMER_BITS-1:0] width;
  region_t               region, region_next;
  logic [TIMER_BITS-1:0] offset, offset_next;
  logic [TIMER_BITS-1:0] divisor, divisor_next;
  logic [PROD_BITS-1:0]  num;
  logic [TIMER_BITS-1:0] rem;
  logic [CNT_BITS-1:0]   cnt;
  logic [TIMER_BITS:0]   trial;

  logic signed [CW-1:0] w_s, lo_out, mid_lo, mid_hi, hi_out, mn_s, mx_s;
  logic signed [CW-1:0] off_neg, off_pos, dvs_neg, dvs_pos;
  logic [TIMER_BITS-1:0] throttle;
  logic [FS_BITS-1:0]    quot;

  // capture / width measurement
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_time <= '0;
      high_seen <= 1'b0;
    end else if (cmd.capture && cfg.enable) begin
      if (pin_level) begin
        rise_time <= capture_time;
        high_seen <= 1'b1;
      end else begin
        high_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && cfg.enable && !pin_level) begin
      width <= high_seen ? capture_time - rise_time : '0;
    end
  end

  // region classification, signed compares at full precision
  always_comb begin
    w_s     = signed'({2'b00, width});
    mn_s    = signed'({2'b00, cfg.width_min});
    mx_s    = signed'({2'b00, cfg.width_max});
    lo_out  = mn_s - signed'({3'b000, cfg.valid_margin});
    mid_lo  = signed'({2'b00, cfg.width_mid}) - signed'({3'b000, cfg.dead_band});
    mid_hi  = signed'({2'b00, cfg.width_mid}) + signed'({3'b000, cfg.dead_band});
    hi_out  = mx_s + signed'({3'b000, cfg.valid_margin});
    off_neg = w_s - mn_s;
    off_pos = w_s - mid_hi;
    dvs_neg = mid_lo - mn_s;
    dvs_pos = mx_s - mid_hi;

    offset_next  = '0;
    divisor_next = '0;
    if (w_s < lo_out) begin
      region_next = RG_OUT;
    end else if (w_s < mn_s) begin
      region_next = RG_NEG;
    end else if (w_s < mid_lo) begin
      region_next  = RG_LIN_NEG;
      offset_next  = off_neg[TIMER_BITS-1:0];
      divisor_next = dvs_neg[TIMER_BITS-1:0];
    end else if (w_s < mid_hi) begin
      region_next = RG_ZERO;
    end else if (w_s < mx_s) begin
      region_next  = RG_LIN_POS;
      offset_next  = off_pos[TIMER_BITS-1:0];
      divisor_next = dvs_pos[TIMER_BITS-1:0];
    end else if (w_s <= hi_out) begin
      region_next = RG_POS;
    end else begin
      region_next = RG_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      region  <= region_next;
      offset  <= offset_next;
      divisor <= divisor_next;
    end
  end

  // multiply, then restoring divide one quotient bit per cycle
  assign trial = {rem, num[PROD_BITS-1]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num <= PROD_BITS'(cfg.full_scale) * PROD_BITS'(offset);
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial[TIMER_BITS]) begin
        rem <= trial[TIMER_BITS-1:0];
        num <= {num[PROD_BITS-2:0], 1'b1};
      end else begin
        rem <= {rem[TIMER_BITS-2:0], num[PROD_BITS-1]};
        num <= {num[PROD_BITS-2:0], 1'b0};
      end
      cnt <= cnt + CNT_BITS'(1);
    end
  end

  assign quot = num[FS_BITS-1:0];

  always_comb begin
    case (region)
      RG_NEG:     throttle = -{1'b0, cfg.full_scale};
      RG_LIN_NEG: throttle = {1'b0, quot} - {1'b0, cfg.full_scale};
      RG_LIN_POS: throttle = {1'b0, quot};
      RG_POS:     throttle = {1'b0, cfg.full_scale};
      default:    throttle = '0;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {width, throttle};
    end
  end

  assign st.fall     = cfg.enable && !pin_level;
  assign st.linear   = (region == RG_LIN_NEG) || (region == RG_LIN_POS);
  assign st.emit     = (region != RG_OUT) || cfg.zero_oor;
  assign st.div_last = (cnt == CNT_BITS'(DIV_STEPS - 1));
  assign st.out_free = !out_valid || out_ready;

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output word overwritten while pending");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul && st.linear) |-> (divisor != '0))
    else $error("zero divisor in linear region");

  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && st.linear) |-> (quot < cfg.full_scale))
    else $error("quotient exceeds full scale");

  a_no_step_outside: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> st.linear)
    else $error("divider stepping for a saturated region");

endmodule

// ===== rtl/rc_pulse_throttle_decoder.sv =====
// RC pulse throttle decoder. Each input word is a capture event: s_tdata holds
// the 16-bit microsecond timestamp, s_tuser the pin level after the edge. Rising
// edges store the time; falling edges measure the high width (mod 65536, zero
// if no rise was seen) and map it to a signed throttle in +/- full_scale with a
// neutral dead band around width_mid. Rising edges and any event while enable
// is clear produce no output word. One event is handled at a time. A falling
// edge is classified, then a 15x16 multiply runs; a linear-region width then
// goes through a 31-step restoring divider, while a saturated or dead-band width
// skips it. The result sits in an output register, so the next event is taken
// while it waits. The user must write registers through cfg_we/cfg_index/
// cfg_data only while the block is idle; the block does not enforce this.
module rc_pulse_throttle_decoder
  import rptd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  reg_idx_t            cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,   // [15:0] capture_time
  input  logic                s_tuser,   // [0] pin_level
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata    // [15:0] throttle, [31:16] pulse_width
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;

  rptd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rptd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  rptd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .st           (st),
    .capture_time (s_tdata),
    .pin_level    (s_tuser),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_data     (m_tdata)
  );

endmodule

// ===== tb/rc_pulse_throttle_decoder_test.sv =====
module rc_pulse_throttle_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rptd_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 150;

  typedef struct {
    logic signed [15:0] throttle;
    logic [15:0]        width;
  } throttle_word_t;

  class throttle_scoreboard;
    cfg_t           cfg;
    logic [15:0]    rise_time;
    bit             high_seen;
    throttle_word_t pending[$];
    int             errors;
    int             words_in;
    int             results;
    int             out_of_range;

    function new();
      cfg.enable       = 1'b0;
      cfg.width_min    = 16'd1000;
      cfg.width_mid    = 16'd1500;
      cfg.width_max    = 16'd2000;
      cfg.dead_band    = 15'd20;
      cfg.valid_margin = 15'd200;
      cfg.full_scale   = 15'd1000;
      cfg.zero_oor     = 1'b1;
      rise_time = '0;
      high_seen = 1'b0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] val);
      case (idx)
        REG_ENABLE:       cfg.enable = val[0];
        REG_WIDTH_MIN:    cfg.width_min = val;
        REG_WIDTH_MID:    cfg.width_mid = val;
        REG_WIDTH_MAX:    cfg.width_max = val;
        REG_DEAD_BAND:    cfg.dead_band = val[14:0];
        REG_VALID_MARGIN: cfg.valid_margin = val[14:0];
        REG_FULL_SCALE:   cfg.full_scale = val[FS_BITS-1:0];
        REG_ZERO_OOR:     cfg.zero_oor = val[0];
        default: ;
      endcase
    endfunction

    // returns 0 when the width falls outside the accepted margins
    function bit width_to_throttle(logic [15:0] width, output logic signed [15:0] thr);
      longint w, mn, md, mx, db, vm, fs, t;
      w = width;
      mn = cfg.width_min;
      md = cfg.width_mid;
      mx = cfg.width_max;
      db = cfg.dead_band;
      vm = cfg.valid_margin;
      fs = cfg.full_scale;
      t = 0;
      width_to_throttle = 1'b1;
      if (w < mn - vm) width_to_throttle = 1'b0;
      else if (w < mn) t = -fs;
      else if (w < md - db) t = -fs + (fs * (w - mn)) / (md - db - mn);
      else if (w < md + db) t = 0;
      else if (w < mx) t = (fs * (w - (md + db))) / (mx - (md + db));
      else if (w <= mx + vm) t = fs;
      else width_to_throttle = 1'b0;
      thr = t[15:0];
    endfunction

    function void note_event(logic [15:0] t, logic lvl);
      throttle_word_t e;
      logic [15:0] w;
      words_in++;
      if (!cfg.enable) return;
      if (lvl) begin
        rise_time = t;
        high_seen = 1'b1;
        return;
      end
      w = high_seen ? t - rise_time : 16'd0;
      high_seen = 1'b0;
      e.width = w;
      if (width_to_throttle(w, e.throttle)) begin
        pending.push_back(e);
      end else if (cfg.zero_oor) begin
        out_of_range++;
        pending.push_back(e);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_word(logic [31:0] d);
      throttle_word_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word %h", d));
        return;
      end
      e = pending.pop_front();
      results++;
      if (d[15:0] !== e.throttle)
        report($sformatf("throttle %0d, expected %0d (width %0d)",
                         $signed(d[15:0]), e.throttle, e.width));
      if (d[31:16] !== e.width)
        report($sformatf("pulse_width %0d, expected %0d", d[31:16], e.width));
    endtask
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  reg_idx_t            cfg_index = REG_ENABLE;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [31:0]         m_tdata;

  throttle_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet = 0;
  int settings = 1;

  rc_pulse_throttle_decoder u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // monitor, receiver backpressure and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_event(s_tdata, s_tuser);
      if (m_tvalid && m_tready) sb.check_word(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic int idle_gap();
    int g;
    g = 0;
    while (g < 40 && $urandom_range(99) < send_idle_pct) g++;
    return g;
  endfunction

  task automatic send_word(input logic [15:0] t, input logic lvl);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= t;
    s_tuser <= lvl;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    gap = idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic pulse(input logic [15:0] t, input logic [15:0] w);
    send_word(t, 1'b1);
    send_word(t + w, 1'b0);
  endtask

  // wait until every expected word is out and the block has gone quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_program(input cfg_t c);
    reg_idx_t idx;
    logic [15:0] val;
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      case (idx)
        REG_ENABLE:       val = 16'(c.enable);
        REG_WIDTH_MIN:    val = c.width_min;
        REG_WIDTH_MID:    val = c.width_mid;
        REG_WIDTH_MAX:    val = c.width_max;
        REG_DEAD_BAND:    val = 16'(c.dead_band);
        REG_VALID_MARGIN: val = 16'(c.valid_margin);
        REG_FULL_SCALE:   val = 16'(c.full_scale);
        default:          val = 16'(c.zero_oor);
      endcase
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
      sb.write_reg(idx, val);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic cfg_enable(input logic en);
    cfg_we <= 1'b1;
    cfg_index <= REG_ENABLE;
    cfg_data <= 16'(en);
    @(posedge clk);
    sb.write_reg(REG_ENABLE, 16'(en));
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t phase_cfg(int ph);
    cfg_t c;
    c.enable = 1'b1;
    c.width_min = 16'd1000;
    c.width_mid = 16'd1500;
    c.width_max = 16'd2000;
    c.dead_band = 15'd20;
    c.valid_margin = 15'd200;
    c.full_scale = 15'd1000;
    c.zero_oor = 1'b1;
    case (ph)
      1: begin
        c.dead_band = 15'd0;
        c.valid_margin = 15'd0;
        c.full_scale = 15'd32767;
        c.zero_oor = 1'b0;
      end
      2: begin
        c.width_min = 16'd0;
        c.width_mid = 16'd32768;
        c.width_max = 16'd65535;
        c.dead_band = 15'd32767;
        c.valid_margin = 15'd32767;
        c.full_scale = 15'd1;
      end
      3, 6: begin
        c.width_min = 16'($urandom_range(30000));
        c.width_mid = c.width_min + 16'($urandom_range(15000));
        c.width_max = c.width_mid + 16'($urandom_range(15000));
        c.dead_band = 15'($urandom_range(3000));
        c.valid_margin = 15'($urandom_range(5000));
        c.full_scale = 15'($urandom_range(32767, 1));
        c.zero_oor = (ph == 3);
      end
      4: begin
        c.width_min = 16'($urandom);
        c.width_mid = 16'($urandom);
        c.width_max = 16'($urandom);
        c.dead_band = 15'($urandom);
        c.valid_margin = 15'($urandom);
        c.full_scale = 15'($urandom_range(32767, 1));
        c.zero_oor = 1'($urandom);
      end
      5: begin
        c.width_min = 16'd1500;
        c.width_max = 16'd1500;
        c.dead_band = 15'd0;
      end
      7: begin
        c.dead_band = 15'd1;
        c.valid_margin = 15'd32767;
        c.full_scale = 15'd32767;
        c.zero_oor = 1'b0;
      end
      default: ;
    endcase
    return c;
  endfunction

  // width aimed at the region edges, the linear-region middles or anywhere, for the current settings
  function automatic logic [15:0] pick_width();
    int mn, md, mx, db, vm, w;
    mn = int'(sb.cfg.width_min);
    md = int'(sb.cfg.width_mid);
    mx = int'(sb.cfg.width_max);
    db = int'(sb.cfg.dead_band);
    vm = int'(sb.cfg.valid_margin);
    w = int'($urandom_range(4)) - 2;
    case ($urandom_range(9))
      0: w += mn - vm;
      1: w += mn;
      2: w += md - db;
      3: w += md + db;
      4: w += mx;
      5: w += mx + vm;
      6: w = (mn + md - db) / 2 + int'($urandom_range(128)) - 64;
      7: w = (md + db + mx) / 2 + int'($urandom_range(128)) - 64;
      default: w = int'($urandom_range(65535));
    endcase
    if (w < 0) w = 0;
    if (w > 65535) w = 65535;
    return w[15:0];
  endfunction

  initial begin
    int n;
    bit paused;
    logic [15:0] t;
    int kind;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_enable(1'b1);

    // directed words on the reset settings
    send_word(16'd4321, 1'b0);          // fall with no rise seen
    pulse(16'd100, 16'd799);
    pulse(16'd0, 16'd800);
    pulse(16'd65535, 16'd1250);
    pulse(16'd65000, 16'd1480);         // wraps past zero
    pulse(16'd7, 16'd1519);
    pulse(16'd30000, 16'd1760);
    pulse(16'd12, 16'd2200);
    pulse(16'd40000, 16'd2201);
    pulse(16'd1, 16'd65535);
    send_word(16'd500, 1'b1);           // second rise restarts the pulse
    send_word(16'd900, 1'b1);
    send_word(16'd2400, 1'b0);
    send_word(16'd3000, 1'b1);          // disabled fall must not touch the rise
    settle();
    cfg_enable(1'b0);
    send_word(16'd3200, 1'b0);
    settle();
    cfg_enable(1'b1);
    send_word(16'd4900, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      cfg_program(phase_cfg(ph));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      n = 0;
      paused = 1'b0;
      while (n < PHASE_WORDS) begin
        if (!paused && n >= PHASE_WORDS / 2) begin
          paused = 1'b1;
          settle();
          if (ph == 5) begin
            cfg_enable(1'b0);
            repeat (10) send_word(16'($urandom), 1'($urandom));
            settle();
            cfg_enable(1'b1);
          end
        end
        t = 16'($urandom);
        kind = $urandom_range(99);
        if (kind < 80) begin
          pulse(t, pick_width());
          n += 2;
        end else if (kind < 88) begin
          send_word(t, 1'b0);
          n += 1;
        end else if (kind < 94) begin
          send_word(t, 1'b1);
          n += 1;
        end else begin
          send_word(t, 1'b1);
          t = t + 16'($urandom_range(3000));
          send_word(t, 1'b1);
          send_word(t + pick_width(), 1'b0);
          n += 3;
        end
      end
    end
    settle();

    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected words never arrived", sb.pending.size()));
    $display("Sent %0d capture words across %0d register settings; checked %0d results,",
             sb.words_in, settings, sb.results);
    $display("%0d of them out-of-range zeros, under all idle and stall mixes.",
             sb.out_of_range);
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
